FILE: sv/wbrm_pkg.sv
// ----------------------------------------------------------------------------
// wbrm_pkg
// shared widths, constants and request codes of the windowed beat rate meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbrm_pkg;

  localparam int RING_DEPTH = 40;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int TIME_W = 31;
  localparam int AGE_W  = TIME_W + 1;
  localparam int WIN_W  = 20;
  localparam int BPM_W  = 22;
  localparam int REQ_W  = 2;

  localparam int MS_PER_MIN = 60000;
  localparam int MS_W       = 16;
  localparam int NUM_W      = CNT_W + MS_W;
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int SAT_W      = (NUM_W > BPM_W) ? NUM_W : BPM_W;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(10000);
  localparam logic [BPM_W-1:0] BPM_MAX      = '1;

  localparam logic [REQ_W-1:0] REQ_BEAT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam int  PADDR_W    = 3;
  localparam int  PDATA_W    = 32;
  localparam logic REG_WINDOW = 1'b0;

endpackage

`default_nettype wire

FILE: sv/wbrm_ram.sv
// ----------------------------------------------------------------------------
// wbrm_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/wbrm_div.sv
// ----------------------------------------------------------------------------
// wbrm_div
// restoring divider, one quotient bit per cycle, for the rate computation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbrm_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [wbrm_pkg::NUM_W-1:0]   num,
  input  wire logic [wbrm_pkg::TIME_W-1:0]  den,
  output logic                              done,
  output logic      [wbrm_pkg::NUM_W-1:0]   quot
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [wbrm_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [wbrm_pkg::NUM_W-1:0]       num_r, num_nxt;
  logic [wbrm_pkg::NUM_W-1:0]       quot_r, quot_nxt;
  logic [wbrm_pkg::TIME_W-1:0]      den_r, den_nxt;
  logic [wbrm_pkg::TIME_W:0]        rem_r, rem_nxt;
  logic [wbrm_pkg::TIME_W:0]        rem_sh;
  logic                             ge;

  assign rem_sh = {rem_r[wbrm_pkg::TIME_W-1:0], num_r[wbrm_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = wbrm_pkg::DIV_CNT_W'(wbrm_pkg::NUM_W - 1);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quot_nxt = '0;
    end else if (busy_r) begin
      num_nxt  = {num_r[wbrm_pkg::NUM_W-2:0], 1'b0};
      rem_nxt  = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quot_nxt = {quot_r[wbrm_pkg::NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

FILE: sv/windowed_beat_rate_meter_top.sv
// ----------------------------------------------------------------------------
// windowed_beat_rate_meter_top
// beat and clear items keep the block idle, so it takes the next item at once
// a query stalls the input while it runs: one ram read per ring entry, then the
// bit-serial divider (skipped when there is no rate to divide), then the output
// register; while the previous result is still stalled at the output, the query
// waits before it loads the output register
// synchronous active-low reset clears the valid bits, write pointer, window
// register (to 10000 ms), the fsm and its flags; the timestamp ram is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_beat_rate_meter_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [wbrm_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [wbrm_pkg::TIME_W-1:0]     in_time_ms,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [wbrm_pkg::BPM_W-1:0]      out_beats_per_minute,
  output logic                                 out_no_rate,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wbrm_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [wbrm_pkg::PDATA_W-1:0]    pwdata,
  output logic      [wbrm_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic [wbrm_pkg::WIN_W-1:0]        win_r, win_nxt;
  logic [wbrm_pkg::RING_DEPTH-1:0]   valid_r, valid_nxt;
  logic [wbrm_pkg::PTR_W-1:0]        wp_r, wp_nxt;
  logic [wbrm_pkg::TIME_W-1:0]       now_r, now_nxt;
  logic [wbrm_pkg::PTR_W-1:0]        iss_r, iss_nxt;
  logic                              iss_done_r, iss_done_nxt;
  logic                              pv_r, pv_nxt;
  logic                              plast_r, plast_nxt;
  logic                              phit_r, phit_nxt;
  logic [wbrm_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [wbrm_pkg::TIME_W-1:0]       early_r, early_nxt;
  logic [wbrm_pkg::TIME_W-1:0]       late_r, late_nxt;
  logic [wbrm_pkg::BPM_W-1:0]        res_bpm_r, res_bpm_nxt;
  logic                              res_nr_r, res_nr_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [wbrm_pkg::BPM_W-1:0]        out_bpm_r, out_bpm_nxt;
  logic                              out_nr_r, out_nr_nxt;

  logic                              in_acc;
  logic                              out_acc;
  logic                              cfg_wr;
  logic                              ram_we;
  logic                              ram_re;
  logic [wbrm_pkg::TIME_W-1:0]       ram_rdata;
  logic signed [wbrm_pkg::AGE_W-1:0] age;
  logic                              in_win;
  logic                              div_start;
  logic                              div_done;
  logic [wbrm_pkg::NUM_W-1:0]        div_num;
  logic [wbrm_pkg::TIME_W-1:0]       span;
  logic [wbrm_pkg::NUM_W-1:0]        div_quot;
  logic [wbrm_pkg::SAT_W-1:0]        quot_ext;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == wbrm_pkg::REG_WINDOW);
  assign ram_we  = in_acc && (in_req_type == wbrm_pkg::REQ_BEAT);
  assign ram_re  = (state_r == ST_SCAN) && !iss_done_r;

  assign age    = $signed({1'b0, now_r}) - $signed({1'b0, ram_rdata});
  assign in_win = age < $signed({{(wbrm_pkg::AGE_W - wbrm_pkg::WIN_W){1'b0}}, win_r});

  assign span      = late_r - early_r;
  assign div_num   = wbrm_pkg::NUM_W'(cnt_r) * wbrm_pkg::NUM_W'(wbrm_pkg::MS_PER_MIN);
  assign div_start = (state_r == ST_CALC) && (cnt_r != '0) && (span != '0);
  assign quot_ext  = wbrm_pkg::SAT_W'(div_quot);

  wbrm_ram #(
    .WIDTH (wbrm_pkg::TIME_W),
    .DEPTH (wbrm_pkg::RING_DEPTH)
  ) u_times (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_time_ms),
    .re    (ram_re),
    .raddr (iss_r),
    .rdata (ram_rdata)
  );

  wbrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = cfg_wr ? pwdata[wbrm_pkg::WIN_W-1:0] : win_r;
    valid_nxt     = valid_r;
    wp_nxt        = wp_r;
    now_nxt       = now_r;
    iss_nxt       = iss_r;
    iss_done_nxt  = iss_done_r;
    pv_nxt        = 1'b0;
    plast_nxt     = 1'b0;
    phit_nxt      = 1'b0;
    cnt_nxt       = cnt_r;
    early_nxt     = early_r;
    late_nxt      = late_r;
    res_bpm_nxt   = res_bpm_r;
    res_nr_nxt    = res_nr_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    out_bpm_nxt   = out_bpm_r;
    out_nr_nxt    = out_nr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_req_type == wbrm_pkg::REQ_BEAT) begin
            valid_nxt[wp_r] = 1'b1;
            wp_nxt = (wp_r == wbrm_pkg::PTR_W'(wbrm_pkg::RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          end else if (in_req_type == wbrm_pkg::REQ_QUERY) begin
            state_nxt    = ST_SCAN;
            now_nxt      = in_time_ms;
            iss_nxt      = '0;
            iss_done_nxt = 1'b0;
            cnt_nxt      = '0;
          end else if (in_req_type == wbrm_pkg::REQ_CLEAR) begin
            valid_nxt = '0;
            wp_nxt    = '0;
          end else begin
            valid_nxt = valid_r;
          end
        end
      end
      ST_SCAN: begin
        if (!iss_done_r) begin
          pv_nxt   = 1'b1;
          phit_nxt = valid_r[iss_r];
          if (iss_r == wbrm_pkg::PTR_W'(wbrm_pkg::RING_DEPTH - 1)) begin
            plast_nxt    = 1'b1;
            iss_done_nxt = 1'b1;
          end else begin
            iss_nxt = iss_r + 1'b1;
          end
        end
        if (pv_r && phit_r && in_win) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == '0 || ram_rdata < early_r) begin
            early_nxt = ram_rdata;
          end
          if (cnt_r == '0 || ram_rdata > late_r) begin
            late_nxt = ram_rdata;
          end
        end
        if (pv_r && plast_r) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end else begin
          res_bpm_nxt = '0;
          res_nr_nxt  = 1'b1;
          state_nxt   = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_bpm_nxt = (quot_ext > wbrm_pkg::SAT_W'(wbrm_pkg::BPM_MAX)) ?
                        wbrm_pkg::BPM_MAX : quot_ext[wbrm_pkg::BPM_W-1:0];
          res_nr_nxt  = 1'b0;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_bpm_nxt   = res_bpm_r;
          out_nr_nxt    = res_nr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= wbrm_pkg::WINDOW_RESET;
      valid_r     <= '0;
      wp_r        <= '0;
      iss_done_r  <= 1'b0;
      pv_r        <= 1'b0;
      plast_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      valid_r     <= valid_nxt;
      wp_r        <= wp_nxt;
      iss_done_r  <= iss_done_nxt;
      pv_r        <= pv_nxt;
      plast_r     <= plast_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r     <= now_nxt;
    iss_r     <= iss_nxt;
    phit_r    <= phit_nxt;
    cnt_r     <= cnt_nxt;
    early_r   <= early_nxt;
    late_r    <= late_nxt;
    res_bpm_r <= res_bpm_nxt;
    res_nr_r  <= res_nr_nxt;
    out_bpm_r <= out_bpm_nxt;
    out_nr_r  <= out_nr_nxt;
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_beats_per_minute = out_bpm_r;
  assign out_no_rate          = out_nr_r;
  assign pready               = 1'b1;
  assign prdata = (paddr[2] == wbrm_pkg::REG_WINDOW) ? wbrm_pkg::PDATA_W'(win_r) : '0;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < wbrm_pkg::PTR_W'(wbrm_pkg::RING_DEPTH))
    else $error("write pointer out of ring range");

  a_beat_marks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req_type == wbrm_pkg::REQ_BEAT) |=> valid_r[$past(wp_r)])
    else $error("beat item did not mark its entry valid");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req_type == wbrm_pkg::REQ_CLEAR) |=> (valid_r == '0) && (wp_r == '0))
    else $error("clear item left ring state behind");

  a_norate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_nr_r |-> out_bpm_r == '0)
    else $error("flagged result carries a nonzero rate");

  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire
